[src/software_timer_table_defines.svh]
// assertion macros shared by the timer table rtl
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// same-cycle check, quiet while reset is asserted
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check of a consequent that follows its antecedent (non-overlapping implication)
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

[src/stt_pkg.sv]
// types and codes shared by the timer table modules
`default_nettype none

package stt_pkg;

    typedef enum logic [1:0] {
        FUNC_ONESHOT  = 2'd0,
        FUNC_PERIODIC = 2'd1,
        FUNC_CANCEL   = 2'd2,
        FUNC_DISPATCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_FIRE  = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] identity;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [15:0] tag;
    } slot_entry_t;

    // operands for the shared unit: sum = a + b, compares a against c
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } alu_op_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        lt;
        logic        eq;
    } alu_res_t;

endpackage

`default_nettype wire

[src/stt_in_if.sv]
// request channel of the timer table
`default_nettype none

interface stt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] interval;
    logic [15:0] handler_tag;
    logic [31:0] cancel_id;
    logic [31:0] now;

    modport source (
        output valid, func, interval, handler_tag, cancel_id, now,
        input  ready
    );
    modport sink (
        input  valid, func, interval, handler_tag, cancel_id, now,
        output ready
    );
endinterface

`default_nettype wire

[src/stt_out_if.sv]
// result channel of the timer table
`default_nettype none

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] timer_id;
    logic [15:0] fired_tag;
    logic        ok;
    logic        last_item;

    modport source (
        output valid, kind, timer_id, fired_tag, ok, last_item,
        input  ready
    );
    modport sink (
        input  valid, kind, timer_id, fired_tag, ok, last_item,
        output ready
    );
endinterface

`default_nettype wire

[src/stt_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/stt_alu.sv]
// shared adder and comparator used by every evaluate step of the slot scan
`default_nettype none

module stt_alu
    import stt_pkg::*;
(
    input  wire alu_op_t  op,
    output alu_res_t      res
);

    always_comb
    begin
        res.sum = op.a + op.b;
        res.lt  = (op.a < op.c);
        res.eq  = (op.a == op.c);
    end

endmodule

`default_nettype wire

[src/software_timer_table.sv]
// top level of the software timer table
// The table holds SLOTS timers whose identity, period, deadline and tag sit in a
// single-port-read RAM, with the in-use flags in flip-flops cleared by reset. Every
// request walks the slots in order, each slot taking a RAM read, then an evaluate
// step on one shared adder/comparator; a dispatch visits every slot and ends with a
// closing done result, while a create or cancel stops at the first slot it hits
// and visits every slot on a miss. The request side is ready only between requests;
// results leave through an output register and the scan stalls only while a result
// is still waiting there. Identities come from a 32-bit counter that wraps; a full
// table answers a create with identity 0 and ok low, and a periodic timer with
// interval 0 is freed when it fires, like a one-shot.
`default_nettype none
`include "software_timer_table_defines.svh"

module software_timer_table
    import stt_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stt_in_if.sink    req,
    stt_out_if.source rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic [31:0]       id_counter_reg, id_counter_next;
    logic [31:0]       current_time_reg, current_time_next;

    func_t             func_reg;
    logic [31:0]       interval_reg;
    logic [15:0]       tag_reg;
    logic [31:0]       cid_reg;

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [31:0]       out_id_reg, out_id_next;
    logic [15:0]       out_tag_reg, out_tag_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              out_free;
    logic              slot_used;
    logic              last_slot;
    logic              hit;
    logic              ram_we;
    logic              ram_re;
    logic [$bits(slot_entry_t)-1:0] ram_rdata;
    slot_entry_t       entry;
    slot_entry_t       wentry;
    alu_op_t           alu_op;
    alu_res_t          alu_res;

    stt_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wentry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    stt_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign entry     = slot_entry_t'(ram_rdata);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign slot_used = used_reg[idx_reg];
    assign last_slot = (idx_reg == IDX_W'(SLOTS - 1));
    assign ram_re    = (state_reg == ST_READ);

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.timer_id  = out_id_reg;
    assign rsp.fired_tag = out_tag_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.last_item = out_last_reg;

    // operand routing for the shared unit
    always_comb
    begin
        alu_op = '0;
        unique case (func_reg)
            FUNC_ONESHOT, FUNC_PERIODIC:
            begin
                alu_op.a = interval_reg;
                alu_op.b = current_time_reg;
            end
            FUNC_CANCEL:
            begin
                alu_op.a = entry.identity;
                alu_op.c = cid_reg;
            end
            FUNC_DISPATCH:
            begin
                alu_op.a = entry.deadline;
                alu_op.b = entry.period;
                alu_op.c = current_time_reg;
            end
            default:
            begin
                alu_op = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (func_reg)
            FUNC_ONESHOT, FUNC_PERIODIC: hit = !slot_used;
            FUNC_CANCEL:                 hit = slot_used && alu_res.eq;
            FUNC_DISPATCH:               hit = slot_used && alu_res.lt;
            default:                     hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        used_next         = used_reg;
        id_counter_next   = id_counter_reg;
        current_time_next = current_time_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_kind_next     = out_kind_reg;
        out_id_next       = out_id_reg;
        out_tag_next      = out_tag_reg;
        out_ok_next       = out_ok_reg;
        out_last_next     = out_last_reg;
        ram_we            = 1'b0;
        wentry            = entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = ST_READ;
                    if (func_t'(req.func) == FUNC_DISPATCH)
                    begin
                        current_time_next = req.now;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!hit)
                begin
                    if (last_slot)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    unique case (func_reg)
                        FUNC_ONESHOT, FUNC_PERIODIC:
                        begin
                            wentry.identity = id_counter_reg + 32'd1;
                            wentry.period   = (func_reg == FUNC_PERIODIC) ? interval_reg : '0;
                            wentry.deadline = alu_res.sum;
                            wentry.tag      = tag_reg;
                            ram_we             = 1'b1;
                            used_next[idx_reg] = 1'b1;
                            id_counter_next    = id_counter_reg + 32'd1;
                            out_kind_next      = KIND_REPLY;
                            out_id_next        = id_counter_reg + 32'd1;
                            out_tag_next       = '0;
                            out_ok_next        = 1'b1;
                            out_last_next      = 1'b1;
                            state_next         = ST_IDLE;
                        end
                        FUNC_CANCEL:
                        begin
                            used_next[idx_reg] = 1'b0;
                            out_kind_next      = KIND_REPLY;
                            out_id_next        = '0;
                            out_tag_next       = '0;
                            out_ok_next        = 1'b1;
                            out_last_next      = 1'b1;
                            state_next         = ST_IDLE;
                        end
                        FUNC_DISPATCH:
                        begin
                            out_kind_next = KIND_FIRE;
                            out_id_next   = entry.identity;
                            out_tag_next  = entry.tag;
                            out_ok_next   = 1'b1;
                            out_last_next = 1'b0;
                            // periodic slots move on, one-shot slots are released
                            if (entry.period != '0)
                            begin
                                wentry.deadline = alu_res.sum;
                                ram_we          = 1'b1;
                            end
                            else
                            begin
                                used_next[idx_reg] = 1'b0;
                            end
                            if (last_slot)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                // closing done for a dispatch, miss reply for create or cancel
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = '0;
                    out_tag_next   = '0;
                    out_last_next  = 1'b1;
                    if (func_reg == FUNC_DISPATCH)
                    begin
                        out_kind_next = KIND_DONE;
                        out_ok_next   = 1'b1;
                    end
                    else
                    begin
                        out_kind_next = KIND_REPLY;
                        out_ok_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            used_reg         <= '0;
            id_counter_reg   <= '0;
            current_time_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            used_reg         <= used_next;
            id_counter_reg   <= id_counter_next;
            current_time_reg <= current_time_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func_t'(req.func);
            interval_reg <= req.interval;
            tag_reg      <= req.handler_tag;
            cid_reg      <= req.cancel_id;
        end
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_tag_reg  <= out_tag_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

    `STT_ASSERT(a_reply_is_last,
        (out_valid_reg && out_kind_reg == KIND_REPLY) |-> out_last_reg,
        "create or cancel reply without last mark")
    `STT_ASSERT(a_fire_not_last,
        (out_valid_reg && out_kind_reg == KIND_FIRE) |-> (out_ok_reg && !out_last_reg),
        "fire result with bad ok or last mark")
    `STT_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready,
        "new transaction taken while a request is in progress")
    `STT_ASSERT(a_id_steps_by_one,
        (id_counter_reg != $past(id_counter_reg)) |->
            (id_counter_reg == $past(id_counter_reg) + 32'd1),
        "identity counter jumped")
    `STT_ASSERT_NEXT(a_result_held, (out_valid_reg && !rsp.ready),
        (out_valid_reg && $stable(out_id_reg) && $stable(out_kind_reg)),
        "stalled result changed")

endmodule

`default_nettype wire

[dv/timer_table_checker.sv]
// transaction monitor, timer table predictor and result comparison
`timescale 1ns / 1ps

module timer_table_checker
    import stt_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stt_in_if         req,
    stt_out_if        rsp,
    output int        fail_count,
    output int        pending
);

    typedef struct {
        kind_t       kind;
        logic [31:0] timer_id;
        logic [15:0] fired_tag;
        logic        ok;
        logic        last_item;
    } timer_result_t;

    // predicted table contents
    bit          in_use   [SLOTS];
    logic [31:0] identity [SLOTS];
    logic [31:0] period   [SLOTS];
    logic [31:0] deadline [SLOTS];
    logic [15:0] tag      [SLOTS];
    logic [31:0] last_identity;
    logic [31:0] table_time;

    timer_result_t awaited_results [$];
    timer_result_t want;

    initial begin
        for (int s = 0; s < SLOTS; s++) in_use[s] = 1'b0;
        last_identity = '0;
        table_time    = '0;
        fail_count    = 0;
        pending       = 0;
    end

    task automatic apply_request(input func_t f, input logic [31:0] interval,
                                 input logic [15:0] handler_tag,
                                 input logic [31:0] cancel_id, input logic [31:0] now);
        timer_result_t res;
        bit            hit;
        hit = 1'b0;
        res = '{kind: KIND_REPLY, timer_id: '0, fired_tag: '0, ok: 1'b0, last_item: 1'b1};
        case (f)
            FUNC_ONESHOT, FUNC_PERIODIC:
            begin
                for (int s = 0; s < SLOTS && !hit; s++)
                begin
                    if (!in_use[s])
                    begin
                        hit           = 1'b1;
                        last_identity = last_identity + 32'd1;
                        in_use[s]     = 1'b1;
                        identity[s]   = last_identity;
                        period[s]     = (f == FUNC_PERIODIC) ? interval : 32'd0;
                        deadline[s]   = interval + table_time;
                        tag[s]        = handler_tag;
                        res.timer_id  = last_identity;
                        res.ok        = 1'b1;
                    end
                end
                awaited_results.push_back(res);
            end
            FUNC_CANCEL:
            begin
                for (int s = 0; s < SLOTS && !hit; s++)
                begin
                    if (in_use[s] && identity[s] == cancel_id)
                    begin
                        hit       = 1'b1;
                        in_use[s] = 1'b0;
                        res.ok    = 1'b1;
                    end
                end
                awaited_results.push_back(res);
            end
            default:
            begin
                table_time = now;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (in_use[s] && deadline[s] < now)
                    begin
                        awaited_results.push_back('{kind: KIND_FIRE, timer_id: identity[s],
                                                    fired_tag: tag[s], ok: 1'b1,
                                                    last_item: 1'b0});
                        // zero period means the timer is done after one shot
                        if (period[s] != 32'd0)
                            deadline[s] = deadline[s] + period[s];
                        else
                            in_use[s] = 1'b0;
                    end
                end
                awaited_results.push_back('{kind: KIND_DONE, timer_id: '0, fired_tag: '0,
                                            ok: 1'b1, last_item: 1'b1});
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (actual !== expected)
        begin
            fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, field, expected, actual);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected, kind %0d id %0h tag %0h",
                             $time, rsp.kind, rsp.timer_id, rsp.fired_tag);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(rsp.kind));
                    check_field("timer_id", want.timer_id, rsp.timer_id);
                    check_field("fired_tag", 32'(want.fired_tag), 32'(rsp.fired_tag));
                    check_field("ok", 32'(want.ok), 32'(rsp.ok));
                    check_field("last_item", 32'(want.last_item), 32'(rsp.last_item));
                end
            end
            if (req.valid && req.ready)
                apply_request(func_t'(req.func), req.interval, req.handler_tag,
                              req.cancel_id, req.now);
            pending = awaited_results.size();
        end
    end

endmodule

[dv/testbench.sv]
// top of the timer table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import stt_pkg::*;

    localparam int SLOTS        = 8;
    localparam int RANDOM_ITEMS = 440;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    bit          sender_busy;
    bit          sink_eager;
    int unsigned ids_guess;
    logic [31:0] clock_guess;

    stt_in_if  req_ch ();
    stt_out_if rsp_ch ();

    software_timer_table #(.SLOTS(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_table_checker #(.SLOTS(SLOTS)) scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic offer_request(input func_t f, input logic [31:0] interval,
                                 input logic [15:0] handler_tag,
                                 input logic [31:0] cancel_id, input logic [31:0] now);
        int gap;
        gap = sender_busy ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.interval    <= interval;
        req_ch.handler_tag <= handler_tag;
        req_ch.cancel_id   <= cancel_id;
        req_ch.now         <= now;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // result side: random stalls, eager streaks, and two long hold-offs
    initial
    begin : result_sink
        int taken;
        int hold;
        taken = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 32 == 0)
                sink_eager = ($urandom_range(0, 2) == 0);
            if (taken == 60 || taken == 400)
                hold = LONG_HOLD;
            else
                hold = sink_eager ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int          pick;
        int unsigned lo;
        logic [31:0] iv;
        logic [31:0] cid;
        logic [31:0] at;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_ONESHOT;
        req_ch.interval    = '0;
        req_ch.handler_tag = '0;
        req_ch.cancel_id   = '0;
        req_ch.now         = '0;
        sender_busy        = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, edge intervals, full table, cancel hit and miss,
        // strict deadline compare, zero-period periodic, deadline wrap
        offer_request(FUNC_DISPATCH, '0, '0, '0, 32'd0);
        offer_request(FUNC_ONESHOT, 32'd0, 16'h0000, '0, '0);
        offer_request(FUNC_PERIODIC, 32'd0, 16'hFFFF, '0, '0);
        offer_request(FUNC_PERIODIC, 32'hFFFF_FFFF, 16'h8000, '0, '0);
        offer_request(FUNC_PERIODIC, 32'd5, 16'h1234, '0, '0);
        offer_request(FUNC_DISPATCH, '0, '0, '0, 32'd0);
        for (int k = 1; k <= 4; k++)
            offer_request(FUNC_ONESHOT, 32'(k * 100), 16'(k), '0, '0);
        offer_request(FUNC_ONESHOT, 32'd7, 16'h5555, '0, '0);
        offer_request(FUNC_PERIODIC, 32'd7, 16'hAAAA, '0, '0);
        offer_request(FUNC_CANCEL, '0, '0, 32'hFFFF_FFFF, '0);
        offer_request(FUNC_CANCEL, '0, '0, 32'd0, '0);
        offer_request(FUNC_CANCEL, '0, '0, 32'd8, '0);
        offer_request(FUNC_CANCEL, '0, '0, 32'd8, '0);
        offer_request(FUNC_DISPATCH, '0, '0, '0, 32'd1);
        offer_request(FUNC_DISPATCH, '0, '0, '0, 32'hFFFF_FFFF);
        offer_request(FUNC_DISPATCH, '0, '0, '0, 32'hFFFF_FFF0);
        offer_request(FUNC_PERIODIC, 32'h20, 16'hABCD, '0, '0);
        offer_request(FUNC_DISPATCH, '0, '0, '0, 32'h11);
        offer_request(FUNC_CANCEL, '0, '0, 32'd3, '0);
        offer_request(FUNC_CANCEL, '0, '0, 32'd4, '0);
        offer_request(FUNC_CANCEL, '0, '0, 32'd9, '0);
        drain_results();

        ids_guess   = 9;
        clock_guess = 32'h11;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                sender_busy = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 34)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    iv = $urandom_range(0, 50);
                else if (pick < 90)
                    iv = '0;
                else
                    iv = $urandom;
                ids_guess++;
                offer_request((pick % 3 == 0) ? FUNC_PERIODIC : FUNC_ONESHOT, iv,
                              16'($urandom_range(0, 65535)), $urandom, $urandom);
            end
            else if (pick < 52)
            begin
                pick = $urandom_range(0, 99);
                lo   = (ids_guess > 12) ? ids_guess - 12 : 1;
                if (pick < 70)
                    cid = $urandom_range(ids_guess, lo);
                else if (pick < 85)
                    cid = $urandom_range(ids_guess, 1);
                else
                    cid = $urandom;
                offer_request(FUNC_CANCEL, $urandom, 16'($urandom), cid, $urandom);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    clock_guess = clock_guess + 32'($urandom_range(0, 30));
                else if (pick < 90)
                    clock_guess = $urandom;
                // otherwise repeat the same time so deadlines equal to it stay put
                at = clock_guess;
                offer_request(FUNC_DISPATCH, $urandom, 16'($urandom), $urandom, at);
            end
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
